// ----- rtl/core/bdqs_pkg.sv -----
// Package for the bounded deque with key search.
// Holds field widths, command and status codes and the result record.
// No dependencies.
package bdqs_pkg;

  // Default sizing of the store
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned DOUT_W = 32;
  localparam int unsigned FIDX_W = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FIND       = 3'd4,
    CMD_REMOVE_KEY = 3'd5,
    CMD_READ_AT    = 3'd6,
    CMD_DELETE_AT  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // One result transaction
  typedef struct packed {
    logic [DOUT_W-1:0] data_out;
    logic [FIDX_W-1:0] found_index;
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic [DOUT_W-1:0] front_data;
  } res_t;

endpackage

// ----- rtl/core/bdqs_mem.sv -----
// Entry store of the deque: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module bdqs_mem #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_WIDTH-1:0]    wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_WIDTH-1:0]    rd_data_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  // Write and read; read data is registered and appears in the cycle after the request
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/bdqs_ctrl.sv -----
// Command sequencer of the deque: decodes a transaction, walks the entry
// store for search and gap closing, and builds the result. Uses bdqs_pkg.
module bdqs_ctrl
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command side
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [VAL_W-1:0]         value_i,
  input  logic [POS_W-1:0]         position_i,
  // result side
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output res_t                     res_o,
  // entry store
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [DATA_WIDTH-1:0]    mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]    mem_rdata_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_RD_WAIT  = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_SHIFT    = 8'b0001_0000,
    S_FRONT_RD = 8'b0010_0000,
    S_FRONT_WT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         head_q, head_d;
  logic                  pend_q, pend_d;
  cmd_e                  cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         pend_i_q, pend_i_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [AW-1:0]         fidx_q, fidx_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;

  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;

  // Physical slot of the entry idx places behind the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(idx);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_ok   = (CMPW'(pos_q) < CMPW'(count_q));
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // Result record, widths fitted to the output fields
  always_comb begin
    res_o.data_out    = DOUT_W'(data_q);
    res_o.found_index = FIDX_W'(fidx_q);
    res_o.status      = status_q;
    res_o.count       = CNT_W'(count_q);
    res_o.front_data  = empty ? '0 : DOUT_W'(front_q);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    pend_d      = pend_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    pend_i_d    = pend_i_q;
    data_d      = data_q;
    fidx_d      = fidx_q;
    status_d    = status_q;
    front_d     = front_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = key_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    unique case (state_q)
      S_IDLE: begin
        // take a transaction and clear the result fields
        if (in_valid_i) begin
          cmd_d    = cmd_e'(cmd_i);
          key_d    = DATA_WIDTH'(value_i);
          pos_d    = position_i;
          data_d   = '0;
          fidx_d   = '0;
          status_d = ST_OK;
          idx_d    = '0;
          pend_d   = 1'b0;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (cmd_q)
          CMD_PUSH_FRONT: begin
            state_d = S_DONE;
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = head_dec;
              head_d      = head_dec;
              count_d     = count_q + CW'(1);
              front_d     = key_q;
            end
          end
          CMD_PUSH_BACK: begin
            state_d = S_DONE;
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = slot_of(head_q, count_q);
              count_d     = count_q + CW'(1);
              if (empty) begin
                front_d = key_q;
              end
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = head_q;
              state_d     = S_RD_WAIT;
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot_of(head_q, count_q - CW'(1));
              state_d     = S_RD_WAIT;
            end
          end
          CMD_FIND, CMD_REMOVE_KEY: begin
            state_d = S_SCAN;
          end
          CMD_READ_AT, CMD_DELETE_AT: begin
            if (!pos_ok) begin
              status_d = ST_MISS;
              state_d  = S_DONE;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot_of(head_q, CW'(pos_q));
              state_d     = S_RD_WAIT;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_RD_WAIT: begin
        // capture the entry read in decode
        data_d = mem_rdata_i;
        case (cmd_q)
          CMD_POP_FRONT: begin
            head_d  = head_inc;
            count_d = count_q - CW'(1);
            state_d = S_FRONT_RD;
          end
          CMD_POP_BACK: begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end
          CMD_DELETE_AT: begin
            idx_d   = CW'(pos_q) + CW'(1);
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_SCAN: begin
        // compare last cycle's entry, issue the next read
        if (pend_q && (mem_rdata_i == key_q)) begin
          fidx_d = AW'(pend_i_q);
          pend_d = 1'b0;
          if (cmd_q == CMD_REMOVE_KEY) begin
            idx_d   = pend_i_q + CW'(1);
            state_d = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end else if (idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_of(head_q, idx_q);
          pend_d      = 1'b1;
          pend_i_d    = idx_q;
          idx_d       = idx_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          status_d = ST_MISS;
          state_d  = S_DONE;
        end
      end

      S_SHIFT: begin
        // move each later entry one place toward the front
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_of(head_q, pend_i_q - CW'(1));
          mem_wdata_o = mem_rdata_i;
        end
        if (idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_of(head_q, idx_q);
          pend_d      = 1'b1;
          pend_i_d    = idx_q;
          idx_d       = idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CW'(1);
            state_d = S_FRONT_RD;
          end
        end
      end

      S_FRONT_RD: begin
        // refresh the cached front entry
        mem_re_o    = 1'b1;
        mem_raddr_o = head_q;
        state_d     = S_FRONT_WT;
      end

      S_FRONT_WT: begin
        front_d = mem_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        // hold until the output register takes the result
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      pend_q  <= pend_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    pend_i_q <= pend_i_d;
    data_q   <= data_d;
    fidx_q   <= fidx_d;
    status_q <= status_d;
    front_q  <= front_d;
  end

endmodule

// ----- rtl/core/bounded_deque_with_search_top.sv -----
// Bounded deque with key search: top level.
//
// Usage:
//   Command channel (in_valid_i / in_stall_o) carries cmd_i, value_i and
//   position_i. A transaction is taken when valid is high and stall low.
//   Exactly one result transaction follows each command on the result
//   channel (out_valid_o / out_stall_i) with data_out_o, found_index_o,
//   status_o, count_o and front_data_o.
//   Commands are worked one at a time. Remove key searches for the key and
//   delete at reads the entry at position; both then move each later entry
//   one place toward the front. The single port pair of the entry memory
//   reads one entry per cycle during search and shift.
//   A finished result waits in an output register, so the next command is
//   taken while the receiver stalls; that command's result waits in the
//   sequencer until the register frees up.
//   Reset empties the deque at once (count and head cleared); the entry
//   memory itself is not cleared.
// Uses bdqs_pkg, bdqs_ctrl and bdqs_mem.
module bounded_deque_with_search_top
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]  position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DOUT_W-1:0] data_out_o,
  output logic [FIDX_W-1:0] found_index_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [DOUT_W-1:0] front_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  out_valid_q;
  res_t                  res_q;

  bdqs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bdqs_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  // Output register is free when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result transaction
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = res_q.data_out;
  assign found_index_o = res_q.found_index;
  assign status_o      = res_q.status;
  assign count_o       = res_q.count;
  assign front_data_o  = res_q.front_data;

endmodule

// ----- rtl/core/bdqs_checker.sv -----
// Port-level checks for the bounded deque with key search, and the bind
// that attaches them to the top level. Uses bdqs_pkg.
module bdqs_checker
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DOUT_W-1:0] data_out_o,
  input logic [1:0]        status_o,
  input logic [CNT_W-1:0]  count_o,
  input logic [DOUT_W-1:0] front_data_o
);

  // An empty deque shows no front entry
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_o == '0) |-> (front_data_o == '0))
    else $error("front data not zero on empty deque");

  // Failed commands return no data
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (data_out_o == '0))
    else $error("data returned with error status");

  // Empty status only when nothing is stored
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (count_o == '0))
    else $error("empty status with entries present");

  // Full status only at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (count_o == CNT_W'(DEPTH)))
    else $error("full status below capacity");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o)
      && $stable(count_o) && $stable(status_o))
    else $error("result changed while stalled");

endmodule

bind bounded_deque_with_search_top bdqs_checker #(.DEPTH(DEPTH)) u_bdqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .data_out_o   (data_out_o),
  .status_o     (status_o),
  .count_o      (count_o),
  .front_data_o (front_data_o)
);

// ----- tb/bounded_deque_with_search_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_with_search_top: a deque shadow predicts every
// result, which is checked against the result channel under random idling and back-pressure.
// Depends on bdqs_pkg and the RTL of the bounded deque with key search.
module bounded_deque_with_search_top_tb;
  import bdqs_pkg::*;

  localparam int unsigned DQ_DEPTH = DEPTH_DEF;
  localparam int unsigned DQ_DW    = DATA_WIDTH_DEF;
  localparam logic [VAL_W-1:0] DQ_MASK = {VAL_W{1'b1}} >> (VAL_W - DQ_DW);
  // Longest correct stretch without any transaction is the long receiver hold
  // plus one full-length search; allow a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  cmd_i       = '0;
  logic [VAL_W-1:0]  value_i     = '0;
  logic [POS_W-1:0]  position_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DOUT_W-1:0] data_out_o;
  logic [FIDX_W-1:0] found_index_o;
  logic [1:0]        status_o;
  logic [CNT_W-1:0]  count_o;
  logic [DOUT_W-1:0] front_data_o;

  // Deque shadow used for prediction
  logic [DOUT_W-1:0] dq_mem [DQ_DEPTH];
  int unsigned       dq_head  = 0;
  int unsigned       dq_count = 0;

  res_t        pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b1;
  int unsigned rx_hold_len    = 0;

  bounded_deque_with_search_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_out_o    (data_out_o),
    .found_index_o (found_index_o),
    .status_o      (status_o),
    .count_o       (count_o),
    .front_data_o  (front_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Map a position from the front to its circular slot
  function automatic int unsigned dq_slot(input int unsigned idx);
    return (dq_head + idx) % DQ_DEPTH;
  endfunction

  // Locate the first live entry equal to key
  function automatic bit dq_locate(input logic [DOUT_W-1:0] key, output int unsigned where);
    where = 0;
    for (int unsigned i = 0; i < dq_count; i++) begin
      if (dq_mem[dq_slot(i)] == key) begin
        where = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Shift later entries one place toward the front, then shrink
  function automatic void dq_close_gap(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < dq_count; i++)
      dq_mem[dq_slot(i)] = dq_mem[dq_slot(i + 1)];
    dq_count--;
  endfunction

  // Apply one command to the shadow and return the result it yields
  function automatic res_t apply_deque_cmd(input cmd_e op, input logic [VAL_W-1:0] val,
                                           input logic [POS_W-1:0] pos);
    res_t              r;
    logic [DOUT_W-1:0] key;
    int unsigned       where;
    r        = '0;
    r.status = ST_OK;
    key      = DOUT_W'(val & DQ_MASK);
    case (op)
      CMD_PUSH_FRONT: begin
        if (dq_count >= DQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_head         = (dq_head + DQ_DEPTH - 1) % DQ_DEPTH;
          dq_mem[dq_head] = key;
          dq_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (dq_count >= DQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_mem[dq_slot(dq_count)] = key;
          dq_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = dq_mem[dq_head];
          dq_head    = (dq_head + 1) % DQ_DEPTH;
          dq_count--;
        end
      end
      CMD_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          dq_count--;
          r.data_out = dq_mem[dq_slot(dq_count)];
        end
      end
      CMD_FIND: begin
        if (dq_locate(key, where)) r.found_index = FIDX_W'(where);
        else r.status = ST_MISS;
      end
      CMD_REMOVE_KEY: begin
        if (dq_locate(key, where)) begin
          r.found_index = FIDX_W'(where);
          dq_close_gap(where);
        end else begin
          r.status = ST_MISS;
        end
      end
      CMD_READ_AT: begin
        if (pos < dq_count) r.data_out = dq_mem[dq_slot(pos)];
        else r.status = ST_MISS;
      end
      default: begin
        if (pos < dq_count) begin
          r.data_out = dq_mem[dq_slot(pos)];
          dq_close_gap(pos);
        end else begin
          r.status = ST_MISS;
        end
      end
    endcase
    r.count      = CNT_W'(dq_count);
    r.front_data = (dq_count > 0) ? dq_mem[dq_head] : '0;
    return r;
  endfunction

  // Offer one command; idle between bursts, hold until accepted, then predict
  task automatic send_cmd(input cmd_e op, input logic [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_deque_cmd(op, val, pos));
  endtask

  // Pick a key that is currently stored (deque must not be empty)
  function automatic logic [VAL_W-1:0] pick_live_key();
    return VAL_W'(dq_mem[dq_slot($urandom_range(0, dq_count - 1))]);
  endfunction

  // Mix fully random words, a small pool for duplicates, extremes and live keys
  function automatic logic [VAL_W-1:0] pick_value(input cmd_e op);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ((op == CMD_FIND || op == CMD_REMOVE_KEY) && dq_count > 0 && roll < 70)
      return pick_live_key();
    if (roll < 55) return $urandom();
    if (roll < 85) return VAL_W'($urandom_range(0, 7));
    return (roll < 92) ? '0 : '1;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (dq_count > 0 && $urandom_range(0, 99) < 70)
      return POS_W'($urandom_range(0, dq_count - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Empty-store errors, ends, extremes, duplicates, search and removal by key and index
  task automatic test_directed();
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '1, '1);
    send_cmd(CMD_FIND, '0, '0);
    send_cmd(CMD_REMOVE_KEY, '1, '0);
    send_cmd(CMD_READ_AT, '0, '0);
    send_cmd(CMD_DELETE_AT, '0, '1);
    send_cmd(CMD_PUSH_BACK, '0, '0);
    send_cmd(CMD_PUSH_FRONT, '1, '1);
    send_cmd(CMD_PUSH_BACK, 32'h8000_0001, '0);
    send_cmd(CMD_PUSH_FRONT, 32'h1234_5678, '0);
    send_cmd(CMD_FIND, '1, '0);
    send_cmd(CMD_FIND, '0, '0);
    send_cmd(CMD_FIND, 32'h0000_0005, '0);
    send_cmd(CMD_READ_AT, '0, 6'd0);
    send_cmd(CMD_READ_AT, '0, 6'd3);
    send_cmd(CMD_READ_AT, '0, 6'd4);
    send_cmd(CMD_READ_AT, '0, '1);
    send_cmd(CMD_PUSH_BACK, '1, '0);
    send_cmd(CMD_FIND, '1, '0);
    send_cmd(CMD_REMOVE_KEY, '1, '0);
    send_cmd(CMD_DELETE_AT, '0, 6'd1);
    send_cmd(CMD_DELETE_AT, '0, 6'd3);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_DELETE_AT, '0, 6'd0);
    send_cmd(CMD_POP_BACK, '0, '0);
  endtask

  // Fill to capacity, hit the full case, then search and compact at full length
  task automatic test_fill_to_full();
    while (dq_count < DQ_DEPTH) send_cmd(CMD_PUSH_BACK, $urandom(), POS_W'($urandom()));
    send_cmd(CMD_PUSH_FRONT, $urandom(), '0);
    send_cmd(CMD_PUSH_BACK, '1, '1);
    send_cmd(CMD_READ_AT, '0, POS_W'(DQ_DEPTH - 1));
    send_cmd(CMD_FIND, VAL_W'(dq_mem[dq_slot(DQ_DEPTH - 1)]), '0);
    send_cmd(CMD_REMOVE_KEY, VAL_W'(dq_mem[dq_slot(DQ_DEPTH - 1)]), '0);
    send_cmd(CMD_PUSH_FRONT, $urandom(), '0);
    send_cmd(CMD_DELETE_AT, '0, '0);
    send_cmd(CMD_PUSH_FRONT, '0, '0);
    send_cmd(CMD_DELETE_AT, '0, POS_W'(DQ_DEPTH - 1));
    repeat (20) send_cmd(cmd_e'($urandom_range(2, 3)), $urandom(), '0);
  endtask

  // Hold the receiver off for a long stretch while commands keep coming
  task automatic test_backpressure();
    cmd_e op;
    gaps_on     = 1'b0;
    rx_hold_len = 400;
    repeat (48) begin
      op = ($urandom_range(0, 1) != 0) ? cmd_e'($urandom_range(0, 1))
                                       : cmd_e'($urandom_range(2, 7));
      send_cmd(op, pick_value(op), pick_position());
    end
    gaps_on = 1'b1;
  endtask

  // Random traffic in segments that lean toward filling or draining the store
  task automatic test_random(input int unsigned n_items);
    int unsigned push_pct, seg_left, roll;
    cmd_e        op;
    seg_left = 0;
    push_pct = 50;
    repeat (n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 150);
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) op = ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      else op = cmd_e'($urandom_range(2, 7));
      send_cmd(op, pick_value(op), pick_position());
    end
  endtask

  // Drive receiver stall in stretches of varying pattern; honor long hold requests
  initial begin : rx_stall_gen
    int unsigned mode, span, hold;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int unsigned k = 0; k < span; k++) begin
        @(posedge clk_i);
        if (rx_hold_len != 0) begin
          hold        = rx_hold_len;
          rx_hold_len = 0;
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
        end
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          2:       out_stall_i <= ((k % 5) < 2);
          default: out_stall_i <= ((k / 8) % 2 == 1);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("ERROR: unexpected result data %h idx %0d st %0d cnt %0d front %h",
                   data_out_o, found_index_o, status_o, count_o, front_data_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data_out || found_index_o !== want.found_index ||
            status_o !== want.status || count_o !== want.count ||
            front_data_o !== want.front_data) begin
          if (mismatch_count < 10) begin
            $display("ERROR: exp data %h idx %0d st %0d cnt %0d front %h", want.data_out,
                     want.found_index, want.status, want.count, want.front_data);
            $display("       got data %h idx %0d st %0d cnt %0d front %h", data_out_o,
                     found_index_o, status_o, count_o, front_data_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  // End the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : main_seq
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_to_full();
    test_backpressure();
    test_random(1200);
    in_valid_i <= 1'b0;
    // Wait for outstanding results, then let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- bounded_deque_with_search_top.f -----
rtl/core/bdqs_pkg.sv
rtl/core/bdqs_mem.sv
rtl/core/bdqs_ctrl.sv
rtl/core/bounded_deque_with_search_top.sv
rtl/core/bdqs_checker.sv
tb/bounded_deque_with_search_top_tb.sv
